[design/mscg_pkg.sv]
// Shared types and constants for the multi-stop color gradient block.
`timescale 1ns / 1ps
package mscg_pkg;

  // Field widths.
  localparam int TIME_W  = 17;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int STOP_W  = TIME_W + COLOR_W;
  localparam int SEGC_W  = 3;
  localparam int CFG_IDX_W = 3;
  // Blend numerator: an 8-bit channel times a 17-bit span, summed twice.
  localparam int NUM_W   = CH_W + TIME_W;

  // Register index of the segment count; stop k sits at index k + 1.
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 3'd0;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [COLOR_W-1:0] rgba;
  } stop_t;

  localparam logic [SEGC_W-1:0] SEG_COUNT_RST = 3'd1;
  localparam stop_t STOP_FIRST_RST = '{t: 17'd0, rgba: 32'hFFFF_FFFF};
  localparam stop_t STOP_OTHER_RST = '{t: 17'h1_0000, rgba: 32'hFFFF_FF00};

endpackage

[design/multi_stop_color_gradient.sv]
// Piecewise linear RGBA gradient lookup over configurable color stops.
//
// Usage: each input item on in_valid/in_stall carries a Q1.16 life ratio.
// The block scans the stops one per cycle for the first ascending segment
// that holds the ratio (both ends inclusive), then blends the two stop
// colors per channel with one shared restoring divider that resolves one
// quotient bit per cycle, red to alpha. If no segment holds the ratio,
// the color of the stop at the segment count, capped at MAX_STOPS - 1,
// is given. The result item leaves on out_valid/out_stall. in_stall stays
// high from accept until the result moves into the output register; the
// next item can be taken in the cycle after that, even while the result
// waits there. When the receiver stalls, the finished result waits in the
// output register, and a later result waits in the block until it frees up.
// Reset clears the handshake state and restores the default stops and the
// segment count. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while idle, as the block does not enforce it.
`timescale 1ns / 1ps
module multi_stop_color_gradient #(
  parameter int MAX_STOPS = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [mscg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mscg_pkg::STOP_W-1:0]       cfg_wdata,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mscg_pkg::TIME_W-1:0]       in_life_ratio,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mscg_pkg::CH_W-1:0]         out_red,
  output logic [mscg_pkg::CH_W-1:0]         out_green,
  output logic [mscg_pkg::CH_W-1:0]         out_blue,
  output logic [mscg_pkg::CH_W-1:0]         out_alpha
);
  import mscg_pkg::*;

  localparam int SEL_W = $clog2(MAX_STOPS);
  localparam logic [SEGC_W-1:0] LAST_SEG = SEGC_W'(MAX_STOPS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // Configuration registers.
  logic [SEGC_W-1:0]  seg_cnt_r;
  stop_t              stop_r [MAX_STOPS];

  // Control state.
  logic [1:0]         state_r, state_nxt;
  logic [SEL_W-1:0]   idx_r;
  logic [1:0]         ch_r;
  logic [2:0]         bit_r;
  logic               out_valid_r;

  // Working registers.
  logic [TIME_W-1:0]  ratio_r;
  stop_t              prev_r;
  logic [TIME_W-1:0]  den_r, dh_r, dl_r;
  logic [COLOR_W-1:0] c_lo_r, c_hi_r, res_r;
  logic [NUM_W-1:0]   rem_r;
  logic [CH_W-1:0]    q_r;
  logic [CH_W-1:0]    out_red_r, out_green_r, out_blue_r, out_alpha_r;

  // Datapath signals.
  logic [SEGC_W-1:0]  limit3;
  logic [SEL_W-1:0]   limit;
  stop_t              cur;
  logic               hit;
  logic               out_free;
  logic [CH_W-1:0]    c_lo_ch, c_hi_ch;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   div_src, div_sh, div_rem;
  logic               qbit;
  logic [CH_W-1:0]    q_nxt;

  // Segments past the last stored stop are never searched.
  assign limit3 = (seg_cnt_r > LAST_SEG) ? LAST_SEG : seg_cnt_r;
  assign limit  = limit3[SEL_W-1:0];

  // Scan: one stop read per cycle, checked against the stop read before it.
  assign cur = stop_r[idx_r];
  assign hit = (idx_r != '0) && (cur.t > prev_r.t) &&
               (ratio_r >= prev_r.t) && (ratio_r <= cur.t);

  // Blend numerator for the channel in work; channel 0 is red in the top byte.
  assign c_lo_ch = CH_W'(c_lo_r >> {~ch_r, 3'b000});
  assign c_hi_ch = CH_W'(c_hi_r >> {~ch_r, 3'b000});
  assign num = NUM_W'(c_lo_ch) * NUM_W'(dh_r) + NUM_W'(c_hi_ch) * NUM_W'(dl_r);

  // Shared restoring divider step; the quotient never exceeds 255.
  assign div_src = (bit_r == 3'd7) ? num : rem_r;
  assign div_sh  = NUM_W'(den_r) << bit_r;
  assign qbit    = (div_src >= div_sh);
  assign div_rem = qbit ? (div_src - div_sh) : div_src;
  assign q_nxt   = (bit_r == 3'd7) ? {{(CH_W-1){1'b0}}, qbit} : {q_r[CH_W-2:0], qbit};

  assign out_free = !out_valid_r || !out_stall;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (hit) state_nxt = ST_DIV;
        else if (idx_r == limit) state_nxt = ST_DONE;
      end
      ST_DIV:    if (bit_r == 3'd0 && ch_r == 2'd3) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      ch_r        <= 2'd0;
      bit_r       <= 3'd7;
      seg_cnt_r   <= SEG_COUNT_RST;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_r[i] <= (i == 0) ? STOP_FIRST_RST : STOP_OTHER_RST;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_SEG_COUNT) seg_cnt_r <= cfg_wdata[SEGC_W-1:0];
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg_we && cfg_index == CFG_IDX_W'(i + 1)) stop_r[i] <= cfg_wdata;
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_IDLE) idx_r <= '0;
      else if (state_r == ST_SEARCH && !hit && idx_r != limit) idx_r <= idx_r + SEL_W'(1);
      if (state_r == ST_SEARCH) begin
        ch_r  <= 2'd0;
        bit_r <= 3'd7;
      end else if (state_r == ST_DIV) begin
        bit_r <= bit_r - 3'd1;
        if (bit_r == 3'd0) ch_r <= ch_r + 2'd1;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) ratio_r <= in_life_ratio;
    if (state_r == ST_SEARCH) begin
      prev_r <= cur;
      if (hit) begin
        den_r  <= cur.t - prev_r.t;
        dh_r   <= cur.t - ratio_r;
        dl_r   <= ratio_r - prev_r.t;
        c_lo_r <= prev_r.rgba;
        c_hi_r <= cur.rgba;
      end else if (idx_r == limit) begin
        res_r <= cur.rgba;
      end
    end
    if (state_r == ST_DIV) begin
      rem_r <= div_rem;
      q_r   <= q_nxt;
      if (bit_r == 3'd0) res_r[{~ch_r, 3'b000} +: CH_W] <= q_nxt;
    end
    if (state_r == ST_DONE && out_free) begin
      out_red_r   <= res_r[31:24];
      out_green_r <= res_r[23:16];
      out_blue_r  <= res_r[15:8];
      out_alpha_r <= res_r[7:0];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

  // A new result appears only when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished item");

  // Division only ever runs on a segment of nonzero width.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (den_r != '0))
    else $error("divider running with zero denominator");

  // The scan never reads past the last stop in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (idx_r <= limit))
    else $error("stop scan ran past the segment count");

  // The block is busy for the whole time an item is in work.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH || state_r == ST_DIV) |=> in_stall)
    else $error("input taken while an item is in work");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the multi-stop color gradient: directed and random ratios.
`timescale 1ns / 1ps
module tb_top;
  import mscg_pkg::*;

  localparam int NUM_STOPS = 7;
  localparam int MAX_SEG = NUM_STOPS - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BASE = CFG_SEG_COUNT + 3'd1;
  localparam logic [TIME_W-1:0] RATIO_ONE = 17'h1_0000;
  localparam logic [TIME_W-1:0] RATIO_MAX = 17'h1_FFFF;
  localparam int MAX_REPORTS = 50;
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } color_t;

  typedef struct {
    logic [TIME_W-1:0] ratio;
    color_t            color;
  } pending_color_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STOP_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_life_ratio;
  logic                 out_valid;
  logic                 out_stall;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic [CH_W-1:0]      out_alpha;

  // Shadow copy of the gradient registers.
  logic [SEGC_W-1:0] seg_count_m;
  stop_t             stop_m [NUM_STOPS];

  pending_color_t pending_colors[$];
  int             err_count;
  int             idle_pct;
  int             stall_pct;
  string          ch_names [4] = '{"red", "green", "blue", "alpha"};

  multi_stop_color_gradient #(
    .MAX_STOPS(NUM_STOPS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_life_ratio(in_life_ratio),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stalls at random with the current percentage.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Counts one mismatch and prints a line for it, up to MAX_REPORTS lines.
  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t ERROR %s", $time, what);
    end
  endtask

  // Restores the shadow registers to their reset values.
  function automatic void reset_gradient_model();
    seg_count_m = SEG_COUNT_RST;
    stop_m[0] = STOP_FIRST_RST;
    for (int k = 1; k < NUM_STOPS; k++) begin
      stop_m[k] = STOP_OTHER_RST;
    end
  endfunction

  // Color the block should give for one life ratio under the shadow registers.
  function automatic color_t blend_color(input logic [TIME_W-1:0] ratio);
    int unsigned       limit;
    int unsigned       seg;
    bit                hit;
    longint unsigned   lo, hi, rl, num;
    logic [COLOR_W-1:0] c_lo, c_hi, acc;
    limit = (seg_count_m > MAX_SEG) ? MAX_SEG : seg_count_m;
    hit = 1'b0;
    seg = 0;
    // The first ascending segment that holds the ratio wins.
    for (int k = 0; k < limit; k++) begin
      if (!hit && stop_m[k+1].t > stop_m[k].t && ratio >= stop_m[k].t &&
          ratio <= stop_m[k+1].t) begin
        hit = 1'b1;
        seg = k;
      end
    end
    if (hit) begin
      lo = stop_m[seg].t;
      hi = stop_m[seg+1].t;
      rl = ratio;
      c_lo = stop_m[seg].rgba;
      c_hi = stop_m[seg+1].rgba;
      for (int ch = 0; ch < 4; ch++) begin
        num = c_lo[31-8*ch -: 8] * (hi - rl) + c_hi[31-8*ch -: 8] * (rl - lo);
        acc[31-8*ch -: 8] = 8'(num / (hi - lo));
      end
    end else begin
      acc = stop_m[limit].rgba;
    end
    return acc;
  endfunction

  // Checks each accepted result item against the oldest expected color.
  always @(posedge clk) begin : check_result
    pending_color_t         want;
    logic [COLOR_W-1:0]     got;
    logic [COLOR_W-1:0]     want_bits;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("result item with no expected color");
      end else begin
        want = pending_colors.pop_front();
        got = {out_red, out_green, out_blue, out_alpha};
        want_bits = want.color;
        for (int ch = 0; ch < 4; ch++) begin
          if (got[31-8*ch -: 8] !== want_bits[31-8*ch -: 8]) begin
            report_mismatch($sformatf("ratio %05h: %s is %02h, expected %02h", want.ratio,
                                      ch_names[ch], got[31-8*ch -: 8],
                                      want_bits[31-8*ch -: 8]));
          end
        end
      end
    end
  end

  task automatic set_pacing(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEG_COUNT) begin
      seg_count_m = data[SEGC_W-1:0];
    end else begin
      stop_m[int'(idx) - int'(CFG_STOP_BASE)] = data;
    end
    @(negedge clk);
  endtask

  task automatic write_stop(input int k, input logic [TIME_W-1:0] t,
                            input logic [COLOR_W-1:0] rgba);
    write_reg(CFG_IDX_W'(int'(CFG_STOP_BASE) + k), {t, rgba});
  endtask

  // Unused upper bits carry noise; only the low bits count.
  task automatic write_seg_count(input logic [SEGC_W-1:0] n);
    logic [STOP_W-1:0] data;
    data = STOP_W'({$urandom, $urandom});
    data[SEGC_W-1:0] = n;
    write_reg(CFG_SEG_COUNT, data);
  endtask

  // Sends one ratio item, with random idle cycles first; returns at a falling edge
  // with in_valid still high, so the caller drives in_valid next.
  task automatic send_ratio(input logic [TIME_W-1:0] ratio);
    pending_color_t entry;
    entry.ratio = ratio;
    entry.color = blend_color(ratio);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_life_ratio <= TIME_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_life_ratio <= ratio;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_colors.push_back(entry);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected color has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  // Ratio choice that favors stop times, their neighbors and the used span.
  function automatic logic [TIME_W-1:0] pick_ratio();
    int unsigned       n, k, lo, hi;
    logic [TIME_W-1:0] r;
    n = (seg_count_m > MAX_SEG) ? MAX_SEG : seg_count_m;
    case ($urandom_range(0, 9)) inside
      [0:3]: begin
        k = $urandom_range(0, n);
        r = TIME_W'(int'(stop_m[k].t) + $urandom_range(0, 2) - 1);
      end
      [4:7]: begin
        lo = stop_m[0].t;
        hi = stop_m[n].t;
        r = TIME_W'($urandom_range(lo, hi));
      end
      8: r = TIME_W'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: r = '0;
          1: r = RATIO_ONE;
          default: r = RATIO_MAX;
        endcase
      end
    endcase
    return r;
  endfunction

  // Loads a random gradient: mostly ascending stops, sometimes arbitrary times.
  task automatic load_random_gradient();
    int unsigned        mode, t, span, cap;
    logic [SEGC_W-1:0]  segc;
    logic [COLOR_W-1:0] rgba;
    mode = $urandom_range(0, 9);
    span = (mode == 9) ? 40000 : 20000;
    cap = (mode >= 7) ? RATIO_MAX : RATIO_ONE;
    t = $urandom_range(0, 8192);
    for (int k = 0; k < NUM_STOPS; k++) begin
      if (mode == 7 || mode == 8) begin
        t = $urandom_range(0, RATIO_MAX);
      end else if (k > 0) begin
        t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, span);
      end
      if (t > cap) begin
        t = cap;
      end
      rgba = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        for (int b = 0; b < 4; b++) begin
          rgba[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end
      write_stop(k, TIME_W'(t), rgba);
    end
    case ($urandom_range(0, 9))
      0: segc = 3'd0;
      1: segc = 3'd7;
      2: segc = 3'd6;
      3: segc = 3'd1;
      default: segc = SEGC_W'($urandom_range(2, 5));
    endcase
    write_seg_count(segc);
  endtask

  // Reset gradient: one white-to-transparent segment, ratios across it, at 1.0 and above.
  task automatic test_default_stops();
    set_pacing(0, 0);
    send_ratio('0);
    send_ratio(17'h0_8000);
    send_ratio(RATIO_ONE);
    send_ratio(17'h1_0001);
    send_ratio(RATIO_MAX);
    send_ratio(17'h0_0001);
    drain_results();
  endtask

  // Zero-width and descending segments, saturated and zero segment counts.
  task automatic test_segment_rules();
    set_pacing(30, 30);
    write_stop(0, 17'h0_0000, 32'h0000_0000);
    write_stop(1, 17'h0_4000, 32'hFFFF_FFFF);
    write_stop(2, 17'h0_4000, 32'h1234_5678);
    write_stop(3, 17'h0_2000, 32'h80C0_E0F0);
    write_stop(4, 17'h0_8000, 32'h00FF_00FF);
    write_stop(5, 17'h1_0000, 32'h5A5A_A5A5);
    write_stop(6, RATIO_MAX, 32'hFF00_00FF);
    write_seg_count(3'd5);
    send_ratio(17'h0_4000);
    send_ratio(17'h0_6000);
    send_ratio(17'h0_9000);
    send_ratio(17'h1_0001);
    send_ratio('0);
    drain_results();
    // A count above six acts as six.
    write_seg_count(3'd7);
    send_ratio(RATIO_MAX);
    send_ratio(17'h1_8000);
    drain_results();
    // With no segments the first stop color comes out.
    write_seg_count(3'd0);
    send_ratio('0);
    send_ratio(17'h0_5000);
    drain_results();
  endtask

  // Full-range segment with channels at 00 and FF.
  task automatic test_color_extremes();
    set_pacing(0, 65);
    write_stop(0, 17'h0_0000, 32'h00FF_00FF);
    write_stop(1, RATIO_MAX, 32'hFF00_FF00);
    write_seg_count(3'd1);
    send_ratio('0);
    send_ratio(RATIO_MAX);
    send_ratio(17'h0_FFFF);
    send_ratio(RATIO_ONE);
    send_ratio(17'h0_0001);
    drain_results();
  endtask

  // Random gradients and ratios under each idling pattern.
  task automatic test_random_gradients();
    int idle_tab [4] = '{0, 65, 0, 30};
    int stall_tab [4] = '{0, 0, 65, 30};
    for (int p = 0; p < 4; p++) begin
      set_pacing(idle_tab[p], stall_tab[p]);
      for (int g = 0; g < 6; g++) begin
        load_random_gradient();
        for (int i = 0; i < 73; i++) begin
          if ($urandom_range(0, 49) == 0) begin
            drain_results();
          end
          send_ratio(pick_ratio());
        end
        drain_results();
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEG_COUNT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_life_ratio = '0;
    idle_pct = 0;
    stall_pct = 0;
    err_count = 0;
    reset_gradient_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_stops();
    test_segment_rules();
    test_color_extremes();
    test_random_gradients();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0 && pending_colors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[multi_stop_color_gradient.f]
design/mscg_pkg.sv
design/multi_stop_color_gradient.sv
tb/tb_top.sv
